FILE: design/ptk_pkg.sv
`timescale 1ns / 1ps

package ptk_pkg;

    // Event kinds
    localparam logic [1:0] MODE_AXIS  = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_POLL  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // Relative axis codes
    localparam logic [9:0] AXIS_X     = 10'd0;
    localparam logic [9:0] AXIS_Y     = 10'd1;
    localparam logic [9:0] AXIS_WHEEL = 10'd8;

    // Key values
    localparam logic signed [15:0] KEY_VAL_UP   = 16'sd0;
    localparam logic signed [15:0] KEY_VAL_DOWN = 16'sd1;
    localparam logic signed [15:0] KEY_VAL_HELD = 16'sd2;

    // Notification codes
    localparam logic [2:0] NOTIFY_NONE  = 3'd0;
    localparam logic [2:0] NOTIFY_DOWN  = 3'd1;
    localparam logic [2:0] NOTIFY_UP    = 3'd2;
    localparam logic [2:0] NOTIFY_HELD  = 3'd3;
    localparam logic [2:0] NOTIFY_WHEEL = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_BOUND_X       = 2'd0;
    localparam logic [1:0] REG_BOUND_Y       = 2'd1;
    localparam logic [1:0] REG_BOUNDS_ENABLE = 2'd2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic signed [15:0] coord_t;

    // Saturate a 17-bit sum to the 16-bit signed range.
    function automatic coord_t sat16(input logic signed [16:0] s);
        coord_t r;
        if (s[16] != s[15])
        begin
            r = s[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            r = s[15:0];
        end
        return r;
    endfunction

    // Saturating move, then optional clamp to 0..bound.
    function automatic coord_t move_axis(input coord_t pos, input coord_t delta,
                                         input logic [14:0] bound, input logic en);
        coord_t p;
        p = sat16({pos[15], pos} + {delta[15], delta});
        if (en)
        begin
            if (p[15])
            begin
                p = '0;
            end
            else if (p[14:0] > bound)
            begin
                p = {1'b0, bound};
            end
        end
        return p;
    endfunction

endpackage

FILE: design/ptk_if.sv
`timescale 1ns / 1ps

interface ptk_evt_if;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [9:0]          code;
    ptk_pkg::coord_t     value;

    modport source (output valid, output mode, output code, output value, input ready);
    modport sink   (input valid, input mode, input code, input value, output ready);
endinterface

interface ptk_res_if;
    logic                valid;
    logic                ready;
    ptk_pkg::coord_t     pos_x;
    ptk_pkg::coord_t     pos_y;
    logic [2:0]          notify;
    logic [9:0]          notify_code;
    ptk_pkg::coord_t     wheel_amount;
    logic                key_is_pressed;

    modport source (output valid, output pos_x, output pos_y, output notify,
                    output notify_code, output wheel_amount, output key_is_pressed,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input notify,
                    input notify_code, input wheel_amount, input key_is_pressed,
                    output ready);
endinterface

FILE: design/pointer_and_key_event_tracker.sv
`timescale 1ns / 1ps

// Pointer and key event tracker. Takes one event beat per clock while the
// result side does not stall, and returns one result beat per event: the event
// is held in an input stage (where the key map read is already back) and the
// position update, clamp and notification land in the result register.
// The key map is a KEY_COUNT x 1 memory with one write and one read port;
// after reset it is cleared one entry per cycle, so evt.ready stays low until
// the clearing pass ends. APB writes are taken at any time but must only
// be issued while no event is in flight.
module pointer_and_key_event_tracker #(
    parameter int KEY_COUNT = 768
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ptk_evt_if.sink                   evt,
    ptk_res_if.source                 res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ptk_pkg::ADDR_W-1:0] paddr,
    input  logic [ptk_pkg::DATA_W-1:0] pwdata,
    output logic [ptk_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int         KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [10:0] KEY_LIMIT = 11'(KEY_COUNT);

    // Configuration
    logic [14:0] bound_x_reg;
    logic [14:0] bound_y_reg;
    logic        bounds_enable_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // Key map and clearing pass
    logic             key_map [KEY_COUNT];
    logic             clr_busy_reg;
    logic [KEY_W-1:0] clr_idx_reg;
    logic             key_rd_reg;

    // Input stage
    logic              s1_valid_reg;
    logic [1:0]        s1_mode_reg;
    logic [9:0]        s1_code_reg;
    ptk_pkg::coord_t   s1_value_reg;

    // Tracker state
    ptk_pkg::coord_t pointer_x_reg, pointer_x_next;
    ptk_pkg::coord_t pointer_y_reg, pointer_y_next;
    ptk_pkg::coord_t wheel_sum_reg, wheel_sum_next;

    // Result register
    logic             res_valid_reg;
    logic [2:0]       notify_reg, notify_next;
    logic [9:0]       notify_code_reg, notify_code_next;
    ptk_pkg::coord_t  wheel_amount_reg, wheel_amount_next;
    logic             pressed_reg, pressed_next;

    logic             accept;
    logic             advance;
    logic             evt_in_range;
    logic             s1_in_range;
    logic [KEY_W-1:0] evt_idx;
    logic             key_wr;
    logic             key_bit;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            ptk_pkg::REG_BOUND_X:       prdata = {17'd0, bound_x_reg};
            ptk_pkg::REG_BOUND_Y:       prdata = {17'd0, bound_y_reg};
            ptk_pkg::REG_BOUNDS_ENABLE: prdata = {31'd0, bounds_enable_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_x_reg       <= '0;
            bound_y_reg       <= '0;
            bounds_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ptk_pkg::REG_BOUND_X:       bound_x_reg       <= pwdata[14:0];
                ptk_pkg::REG_BOUND_Y:       bound_y_reg       <= pwdata[14:0];
                ptk_pkg::REG_BOUNDS_ENABLE: bounds_enable_reg <= pwdata[0];
                default:                    ;
            endcase
        end
    end

    // ---------------- Handshake ----------------
    assign advance   = s1_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign accept    = evt.valid && evt.ready;

    // ---------------- Key map ----------------
    assign evt_in_range = {1'b0, evt.code} < KEY_LIMIT;
    assign evt_idx      = evt.code[KEY_W-1:0];
    // Write at acceptance so the next item's read already sees it.
    assign key_wr       = accept && (evt.mode == ptk_pkg::MODE_KEY) && evt_in_range;
    assign key_bit      = !evt.value[15] && (evt.value != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == KEY_W'(KEY_COUNT - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            key_map[clr_idx_reg] <= 1'b0;
        end
        else if (key_wr)
        begin
            key_map[evt_idx] <= key_bit;
        end
        if (accept)
        begin
            key_rd_reg <= key_map[evt_idx];
        end
    end

    // ---------------- Input stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= evt.mode;
            s1_code_reg  <= evt.code;
            s1_value_reg <= evt.value;
        end
    end

    // ---------------- Update logic ----------------
    assign s1_in_range = {1'b0, s1_code_reg} < KEY_LIMIT;

    always_comb
    begin
        pointer_x_next    = pointer_x_reg;
        pointer_y_next    = pointer_y_reg;
        wheel_sum_next    = wheel_sum_reg;
        notify_next       = ptk_pkg::NOTIFY_NONE;
        notify_code_next  = '0;
        wheel_amount_next = '0;
        pressed_next      = 1'b0;
        unique case (s1_mode_reg)
            ptk_pkg::MODE_AXIS:
            begin
                if (s1_code_reg == ptk_pkg::AXIS_X)
                begin
                    pointer_x_next = ptk_pkg::move_axis(pointer_x_reg, s1_value_reg,
                                                        bound_x_reg, bounds_enable_reg);
                end
                else if (s1_code_reg == ptk_pkg::AXIS_Y)
                begin
                    pointer_y_next = ptk_pkg::move_axis(pointer_y_reg, s1_value_reg,
                                                        bound_y_reg, bounds_enable_reg);
                end
                else if (s1_code_reg == ptk_pkg::AXIS_WHEEL)
                begin
                    wheel_sum_next = ptk_pkg::sat16({wheel_sum_reg[15], wheel_sum_reg}
                                                    + {s1_value_reg[15], s1_value_reg});
                end
            end
            ptk_pkg::MODE_KEY:
            begin
                if (s1_in_range)
                begin
                    if (s1_value_reg == ptk_pkg::KEY_VAL_DOWN)
                    begin
                        notify_next = ptk_pkg::NOTIFY_DOWN;
                    end
                    else if (s1_value_reg == ptk_pkg::KEY_VAL_UP)
                    begin
                        notify_next = ptk_pkg::NOTIFY_UP;
                    end
                    else if (s1_value_reg == ptk_pkg::KEY_VAL_HELD)
                    begin
                        notify_next = ptk_pkg::NOTIFY_HELD;
                    end
                    if (notify_next != ptk_pkg::NOTIFY_NONE)
                    begin
                        notify_code_next = s1_code_reg;
                    end
                end
            end
            ptk_pkg::MODE_POLL:
            begin
                if (wheel_sum_reg != '0)
                begin
                    notify_next       = ptk_pkg::NOTIFY_WHEEL;
                    wheel_amount_next = wheel_sum_reg;
                    wheel_sum_next    = '0;
                end
            end
            default:
            begin
                pressed_next = s1_in_range && key_rd_reg;
            end
        endcase
    end

    // ---------------- State and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_x_reg <= '0;
            pointer_y_reg <= '0;
            wheel_sum_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pointer_x_reg <= pointer_x_next;
            pointer_y_reg <= pointer_y_next;
            wheel_sum_reg <= wheel_sum_next;
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            notify_reg       <= notify_next;
            notify_code_reg  <= notify_code_next;
            wheel_amount_reg <= wheel_amount_next;
            pressed_reg      <= pressed_next;
        end
    end

    // Position register doubles as the result position.
    assign res.valid          = res_valid_reg;
    assign res.pos_x          = pointer_x_reg;
    assign res.pos_y          = pointer_y_reg;
    assign res.notify         = notify_reg;
    assign res.notify_code    = notify_code_reg;
    assign res.wheel_amount   = wheel_amount_reg;
    assign res.key_is_pressed = pressed_reg;

    // ---------------- Assertions ----------------
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !evt.ready)
        else $error("event accepted during key map clear");

    a_wheel_amount_only_on_wheel: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && res.notify != ptk_pkg::NOTIFY_WHEEL) |-> (res.wheel_amount == '0))
        else $error("wheel amount without wheel notification");

    a_wheel_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && res.notify == ptk_pkg::NOTIFY_WHEEL) |-> (res.wheel_amount != '0))
        else $error("wheel notification with zero amount");

    a_code_only_on_key: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && (res.notify == ptk_pkg::NOTIFY_NONE
                       || res.notify == ptk_pkg::NOTIFY_WHEEL)) |-> (res.notify_code == '0))
        else $error("notify code without key notification");

endmodule
